/* sv/tlvsp_pkg.sv */
// ----------------------------------------------------------------------------
// tlvsp_pkg
// Shared types and codes for the streaming tag-length-value parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvsp_pkg;

	// parse phases
	localparam logic [2:0] PH_TAG1  = 3'd0;
	localparam logic [2:0] PH_TAG2  = 3'd1;
	localparam logic [2:0] PH_LEN1  = 3'd2;
	localparam logic [2:0] PH_LENX  = 3'd3;
	localparam logic [2:0] PH_VALUE = 3'd4;
	localparam logic [2:0] PH_ERR   = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TRUNC   = 3'd1;
	localparam logic [2:0] ST_OVERRUN = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_DEEP    = 3'd4;

	// byte roles
	localparam logic [1:0] ROLE_TAG   = 2'd0;
	localparam logic [1:0] ROLE_LEN   = 2'd1;
	localparam logic [1:0] ROLE_VALUE = 2'd2;
	localparam logic [1:0] ROLE_IGN   = 2'd3;

	// header byte values
	localparam logic [7:0]  LEN_ESC16   = 8'hFE;
	localparam logic [7:0]  LEN_ESC32   = 8'hFF;
	localparam logic [31:0] POS_SAT     = 32'hFFFF_FFFF;

	// probe values and commands sent to the level stack
	typedef struct packed {
		logic        push;
		logic        pop;
		logic        clear;
		logic [31:0] next_pos;
		logic [31:0] elem_end;
	} stk_ctl_t;

	// compare results from the level stack
	typedef struct packed {
		logic top_eq;  // innermost open level ends at next_pos
		logic end_gt;  // elem_end lies past the innermost open level
	} stk_stat_t;

	// one result item
	typedef struct packed {
		logic [1:0]  byte_role;
		logic        header_done;
		logic [15:0] tag;
		logic [31:0] value_length;
		logic        constructed;
		logic [3:0]  depth;
		logic [3:0]  levels_closed;
		logic [2:0]  status;
		logic        pdu_done;
	} result_t;

endpackage

`default_nettype wire

/* sv/tlvsp_level_stack.sv */
// ----------------------------------------------------------------------------
// tlvsp_level_stack
// End positions of the open constructed levels, with parallel compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvsp_level_stack #(
	parameter int MAX_DEPTH = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  tlvsp_pkg::stk_ctl_t                 ctl,
	output tlvsp_pkg::stk_stat_t                stat,
	output logic [$clog2(MAX_DEPTH+1)-1:0]      sp,
	output logic [$clog2(MAX_DEPTH+1)-1:0]      close_cnt
);
	import tlvsp_pkg::*;

	localparam int SPW = $clog2(MAX_DEPTH + 1);
	localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [31:0]          ends_q [MAX_DEPTH];
	logic [SPW-1:0]       sp_q;
	logic [MAX_DEPTH-1:0] eq_vec;
	logic [MAX_DEPTH-1:0] gt_vec;
	logic [SPW-1:0]       low_idx;

	// per-level compares; ends never increase towards the top, so the
	// levels that end at next_pos form one run at the top of the stack
	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			eq_vec[i] = (SPW'(i) < sp_q) && (ends_q[i] == ctl.next_pos);
			gt_vec[i] = (SPW'(i) < sp_q) && (ctl.elem_end > ends_q[i]);
		end
	end

	// lowest level of the closing run
	always_comb begin
		low_idx = sp_q;
		for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
			if (eq_vec[i]) begin
				low_idx = SPW'(i);
			end
		end
	end

	assign close_cnt   = sp_q - low_idx;
	assign stat.top_eq = |eq_vec;
	assign stat.end_gt = |gt_vec;
	assign sp          = sp_q;

	// entry storage, no reset
	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clear) begin
			ends_q[sp_q[IW-1:0]] <= ctl.elem_end;
		end
	end

	// stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (ctl.clear) begin
			sp_q <= '0;
		end else if (ctl.push) begin
			sp_q <= sp_q + SPW'(1);
		end else if (ctl.pop) begin
			sp_q <= sp_q - close_cnt;
		end
	end

endmodule

`default_nettype wire

/* sv/tlvsp_parse.sv */
// ----------------------------------------------------------------------------
// tlvsp_parse
// Header parse state and the per-byte decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvsp_parse #(
	parameter int MAX_DEPTH = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire  [7:0]                          data_byte_s1,
	input  wire                                 pdu_last_s1,
	input  tlvsp_pkg::stk_stat_t                stat,
	input  wire  [$clog2(MAX_DEPTH+1)-1:0]      sp,
	input  wire  [$clog2(MAX_DEPTH+1)-1:0]      close_cnt,
	output tlvsp_pkg::stk_ctl_t                 ctl,
	output tlvsp_pkg::result_t                  res,
	output logic [2:0]                          phase,
	output logic [2:0]                          err_code
);
	import tlvsp_pkg::*;

	localparam int SPW = $clog2(MAX_DEPTH + 1);

	logic [2:0]  phase_q,  phase_d;
	logic [15:0] tag_q,    tag_d;
	logic [31:0] len_q,    len_d;
	logic [2:0]  left_q,   left_d;
	logic [31:0] next_q,   next_d;
	logic [31:0] pend_q,   pend_d;
	logic [2:0]  err_q,    err_d;

	logic [32:0]    end_sum;
	logic [31:0]    elem_end;
	logic           complete;
	logic           in_header;
	logic           closing;
	logic           push;
	logic           cons;
	logic [2:0]     err;
	logic [SPW-1:0] sp_new;
	logic [SPW+3:0] dep_ext;
	logic [SPW+3:0] closed_ext;

	assign dep_ext    = {4'd0, sp};
	assign closed_ext = {4'd0, close_cnt} + (SPW + 4)'(1);

	// saturating end position of the element being completed
	assign end_sum  = {1'b0, next_q} + {1'b0, len_d};
	assign elem_end = end_sum[32] ? POS_SAT : end_sum[31:0];

	// per-byte decision
	always_comb begin
		phase_d   = phase_q;
		tag_d     = tag_q;
		len_d     = len_q;
		left_d    = left_q;
		pend_d    = pend_q;
		err_d     = err_q;
		complete  = 1'b0;
		in_header = 1'b1;
		closing   = 1'b0;
		push      = 1'b0;
		cons      = 1'b0;
		err       = ST_OK;
		sp_new    = sp;
		res       = '0;
		res.byte_role = ROLE_IGN;

		if (phase_q != PH_ERR) begin
			res.depth = dep_ext[3:0];
			case (phase_q)
				PH_TAG1: begin
					res.byte_role = ROLE_TAG;
					if (data_byte_s1[7]) begin
						tag_d   = {data_byte_s1, 8'd0};
						phase_d = PH_TAG2;
					end else begin
						tag_d   = {8'd0, data_byte_s1};
						phase_d = PH_LEN1;
					end
				end
				PH_TAG2: begin
					res.byte_role = ROLE_TAG;
					tag_d   = {tag_q[15:8], data_byte_s1};
					phase_d = PH_LEN1;
				end
				PH_LEN1: begin
					res.byte_role = ROLE_LEN;
					len_d = '0;
					if (data_byte_s1 == LEN_ESC16) begin
						left_d  = 3'd2;
						phase_d = PH_LENX;
					end else if (data_byte_s1 == LEN_ESC32) begin
						left_d  = 3'd4;
						phase_d = PH_LENX;
					end else begin
						len_d    = {24'd0, data_byte_s1};
						complete = 1'b1;
					end
				end
				PH_LENX: begin
					res.byte_role = ROLE_LEN;
					len_d = {len_q[23:0], data_byte_s1};
					if (left_q != 3'd0) begin
						left_d = left_q - 3'd1;
					end
					if (left_d == 3'd0) begin
						complete = 1'b1;
					end
				end
				default: begin
					res.byte_role = ROLE_VALUE;
					in_header     = 1'b0;
					if (next_q == pend_q) begin
						closing = 1'b1;
						phase_d = PH_TAG1;
					end
				end
			endcase

			// finished header
			if (complete) begin
				cons = (tag_q[15:8] != 8'd0) ? tag_q[14] : tag_q[6];
				res.header_done  = 1'b1;
				res.tag          = tag_q;
				res.value_length = len_d;
				res.constructed  = cons;
				if (stat.end_gt) begin
					err = ST_OVERRUN;
				end else if (cons) begin
					if (len_d == 32'd0) begin
						err = ST_EMPTY;
					end else if (sp >= SPW'(MAX_DEPTH)) begin
						err = ST_DEEP;
					end else begin
						push    = 1'b1;
						phase_d = PH_TAG1;
					end
				end else if (len_d == 32'd0) begin
					closing = 1'b1;
					phase_d = PH_TAG1;
				end else begin
					pend_d  = elem_end;
					phase_d = PH_VALUE;
				end
			end else if (in_header && stat.top_eq) begin
				err = ST_OVERRUN;
			end

			if (closing) begin
				res.levels_closed = closed_ext[3:0];
				sp_new = sp - close_cnt;
			end else if (push) begin
				sp_new = sp + SPW'(1);
			end

			// end of pdu with an element still open
			if (err == ST_OK && pdu_last_s1 &&
			    (phase_d != PH_TAG1 || sp_new != '0)) begin
				err = ST_TRUNC;
			end
			if (err != ST_OK) begin
				err_d   = err;
				phase_d = PH_ERR;
				res.levels_closed = 4'd0;
			end
		end

		res.status   = err_d;
		res.pdu_done = pdu_last_s1;
	end

	// saturating byte position
	assign next_d = (next_q == POS_SAT) ? next_q : next_q + 32'd1;

	// stack commands
	assign ctl.push     = en && push && !pdu_last_s1;
	assign ctl.pop      = en && closing;
	assign ctl.clear    = en && pdu_last_s1;
	assign ctl.next_pos = next_q;
	assign ctl.elem_end = elem_end;

	assign phase    = phase_q;
	assign err_code = err_q;

	// parse state, back to reset values after the last byte of a pdu
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG1;
			tag_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
			next_q  <= 32'd1;
			pend_q  <= '0;
			err_q   <= ST_OK;
		end else if (en) begin
			if (pdu_last_s1) begin
				phase_q <= PH_TAG1;
				tag_q   <= '0;
				len_q   <= '0;
				left_q  <= '0;
				next_q  <= 32'd1;
				pend_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_d;
				tag_q   <= tag_d;
				len_q   <= len_d;
				left_q  <= left_d;
				next_q  <= next_d;
				pend_q  <= pend_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/tlv_stream_parser_top.sv */
// ----------------------------------------------------------------------------
// tlv_stream_parser_top
// Streaming parser for nested tag-length-value elements, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one PDU byte per cycle and returns one result per byte. A byte sits
// in the input register, the parse logic and the level stack compares
// resolve it combinationally, and the result waits in the output register;
// a new byte is accepted every cycle unless a result is held by out_stall
// while the input register is full. The stack holds up to MAX_DEPTH open
// constructed levels, and all levels that end at a byte close together in
// that byte's cycle. No clearing pass is needed after reset.
`default_nettype none

module tlv_stream_parser_top #(
	parameter int MAX_DEPTH = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         pdu_last,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  byte_role,
	output logic        header_done,
	output logic [15:0] tag,
	output logic [31:0] value_length,
	output logic        constructed,
	output logic [3:0]  depth,
	output logic [3:0]  levels_closed,
	output logic [2:0]  status,
	output logic        pdu_done
);
	import tlvsp_pkg::*;

	localparam int SPW = $clog2(MAX_DEPTH + 1);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           valid_s2;
	result_t        res_s2;
	logic           adv;
	stk_ctl_t       ctl;
	stk_stat_t      stat;
	logic [SPW-1:0] sp;
	logic [SPW-1:0] close_cnt;
	result_t        res;
	logic [2:0]     phase;
	logic [2:0]     err_code;

	// handshake
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= pdu_last;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	tlvsp_parse #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.data_byte_s1(byte_s1),
		.pdu_last_s1 (last_s1),
		.stat        (stat),
		.sp          (sp),
		.close_cnt   (close_cnt),
		.ctl         (ctl),
		.res         (res),
		.phase       (phase),
		.err_code    (err_code)
	);

	tlvsp_level_stack #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.sp       (sp),
		.close_cnt(close_cnt)
	);

	// outputs
	assign out_valid     = valid_s2;
	assign byte_role     = res_s2.byte_role;
	assign header_done   = res_s2.header_done;
	assign tag           = res_s2.tag;
	assign value_length  = res_s2.value_length;
	assign constructed   = res_s2.constructed;
	assign depth         = res_s2.depth;
	assign levels_closed = res_s2.levels_closed;
	assign status        = res_s2.status;
	assign pdu_done      = res_s2.pdu_done;

	// error phase is always backed by a recorded error
	assert property (@(posedge clk) disable iff (!arst_n)
		phase == PH_ERR |-> err_code != ST_OK)
		else $error("error phase without an error code");

	// a recorded error stays until the last byte of the pdu
	assert property (@(posedge clk) disable iff (!arst_n)
		(err_code != ST_OK && !(adv && last_s1)) |=> err_code == $past(err_code))
		else $error("error code changed inside a pdu");

	// ignored bytes carry no header, close nothing and carry an error status
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.byte_role == ROLE_IGN) |->
		(!res_s2.header_done && res_s2.levels_closed == 4'd0 &&
		 res_s2.status != ST_OK))
		else $error("ignored byte with header or close information");

	// a header completes only on a length byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.header_done) |-> res_s2.byte_role == ROLE_LEN)
		else $error("header completed on a non-length byte");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the streaming tag-length-value parser byte by byte.
// ----------------------------------------------------------------------------
// A short table of hand-built PDUs opens the run: reset values, the widest
// tags and lengths, nested closes and the truncation, overrun and empty
// error codes. Random PDUs follow. Most are well formed, with nesting up to
// one level past the stack limit. The rest are cut short, overrun their
// parents, hold empty constructed elements, carry huge lengths or are plain
// noise. Every accepted byte steps a parser model kept here, and each result
// from the block is compared field by field with the oldest prediction.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tlvsp_pkg::*;

	localparam int NEST_LIMIT   = 8;
	localparam int PARSED_ITEMS = 1400;
	localparam int HOLD_CYCLES  = 300;
	localparam int STUCK_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	typedef logic [7:0] octets_t [$];

	typedef enum int {
		FAULT_NONE,
		FAULT_CUT,
		FAULT_OVERRUN,
		FAULT_EMPTY,
		FAULT_NOISE,
		FAULT_HUGE
	} fault_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       fixed;
		result_t    res;
	} stim_row_t;

	// clock, reset and block ports
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        pdu_last  = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  byte_role;
	logic        header_done;
	logic [15:0] tag;
	logic [31:0] value_length;
	logic        constructed;
	logic [3:0]  depth;
	logic [3:0]  levels_closed;
	logic [2:0]  status;
	logic        pdu_done;

	// typed expectation travelling with the byte on offer
	logic    fixed_valid = 1'b0;
	result_t fixed_res   = '0;

	// traffic control shared by sender and receiver
	logic idle_on  = 1'b0;
	logic hold_req = 1'b0;

	// parser model state
	logic [2:0]  phase;
	logic [15:0] hdr_tag;
	logic [31:0] hdr_len;
	logic [2:0]  len_bytes_due;
	logic [31:0] open_ends [NEST_LIMIT];
	logic [3:0]  open_cnt;
	logic [31:0] byte_pos;
	logic [31:0] prim_end;
	logic [2:0]  pdu_status;

	result_t pending_results [$];

	int mismatches     = 0;
	int parsed_items   = 0;
	int results_seen   = 0;
	int pdus_seen      = 0;
	int error_pdus     = 0;
	int deepest        = 0;
	int stuck_cycles   = 0;

	wire in_taken  = in_valid && !in_stall;
	wire out_taken = out_valid && !out_stall;

	tlv_stream_parser_top #(
		.MAX_DEPTH(NEST_LIMIT)
	) i_dut (
		.*
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------

	function automatic void clear_parser();
		phase         = PH_TAG1;
		hdr_tag       = '0;
		hdr_len       = '0;
		len_bytes_due = '0;
		open_cnt      = '0;
		byte_pos      = '0;
		prim_end      = '0;
		pdu_status    = ST_OK;
	endfunction

	// pop every open level that ends just past this byte
	function automatic logic [3:0] close_levels(input logic [31:0] nxt);
		logic [3:0] n;
		n = '0;
		while (open_cnt > 0 && open_cnt <= NEST_LIMIT && open_ends[open_cnt - 1] == nxt) begin
			open_cnt--;
			n++;
		end
		return n;
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b, input logic last);
		result_t     r;
		logic [31:0] nxt;
		logic [32:0] wide_end;
		logic [31:0] elem_end;
		logic        complete;
		logic        in_hdr;
		logic        cons;
		logic [2:0]  err;
		r = '0;
		r.byte_role = ROLE_IGN;
		err = ST_OK;
		nxt = (byte_pos == POS_SAT) ? byte_pos : byte_pos + 32'd1;
		if (phase != PH_ERR) begin
			complete = 1'b0;
			in_hdr = 1'b1;
			r.depth = open_cnt;
			case (phase)
				PH_TAG1: begin
					r.byte_role = ROLE_TAG;
					if (b[7]) begin
						hdr_tag = {b, 8'h00};
						phase = PH_TAG2;
					end else begin
						hdr_tag = {8'h00, b};
						phase = PH_LEN1;
					end
				end
				PH_TAG2: begin
					r.byte_role = ROLE_TAG;
					hdr_tag[7:0] = b;
					phase = PH_LEN1;
				end
				PH_LEN1: begin
					r.byte_role = ROLE_LEN;
					hdr_len = '0;
					if (b == LEN_ESC16) begin
						len_bytes_due = 3'd2;
						phase = PH_LENX;
					end else if (b == LEN_ESC32) begin
						len_bytes_due = 3'd4;
						phase = PH_LENX;
					end else begin
						hdr_len = {24'h0, b};
						complete = 1'b1;
					end
				end
				PH_LENX: begin
					r.byte_role = ROLE_LEN;
					hdr_len = {hdr_len[23:0], b};
					if (len_bytes_due > 0)
						len_bytes_due--;
					if (len_bytes_due == 0)
						complete = 1'b1;
				end
				default: begin
					r.byte_role = ROLE_VALUE;
					in_hdr = 1'b0;
					if (nxt == prim_end) begin
						r.levels_closed = 4'd1 + close_levels(nxt);
						phase = PH_TAG1;
					end
				end
			endcase

			// header finished: place the element against its parent
			if (complete) begin
				wide_end = {1'b0, nxt} + {1'b0, hdr_len};
				elem_end = wide_end[32] ? POS_SAT : wide_end[31:0];
				cons = (hdr_tag[15:8] != 8'h00) ? hdr_tag[14] : hdr_tag[6];
				r.header_done = 1'b1;
				r.tag = hdr_tag;
				r.value_length = hdr_len;
				r.constructed = cons;
				if (open_cnt > 0 && open_cnt <= NEST_LIMIT &&
						elem_end > open_ends[open_cnt - 1]) begin
					err = ST_OVERRUN;
				end else if (cons) begin
					if (hdr_len == 0)
						err = ST_EMPTY;
					else if (open_cnt >= NEST_LIMIT)
						err = ST_DEEP;
					else begin
						open_ends[open_cnt] = elem_end;
						open_cnt++;
						phase = PH_TAG1;
					end
				end else if (hdr_len == 0) begin
					r.levels_closed = 4'd1 + close_levels(nxt);
					phase = PH_TAG1;
				end else begin
					prim_end = elem_end;
					phase = PH_VALUE;
				end
			end else if (in_hdr) begin
				if (open_cnt > 0 && open_cnt <= NEST_LIMIT && open_ends[open_cnt - 1] == nxt)
					err = ST_OVERRUN;
			end

			// anything still open at the end of the pdu is truncated
			if (err == ST_OK && last && (phase != PH_TAG1 || open_cnt != 0))
				err = ST_TRUNC;
			if (err != ST_OK) begin
				pdu_status = err;
				phase = PH_ERR;
				r.levels_closed = '0;
			end
		end
		r.status = pdu_status;
		r.pdu_done = last;
		if (last)
			clear_parser();
		else
			byte_pos = nxt;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// pdu builders
	// ------------------------------------------------------------------

	function automatic logic [15:0] rand_tag(input logic cons);
		logic [15:0] t;
		t = 16'($urandom);
		if ($urandom_range(1) == 1) begin
			t[15] = 1'b1;
			t[14] = cons;
		end else begin
			t[15:7] = '0;
			t[6] = cons;
		end
		return t;
	endfunction

	// tag and length, with the length form picked at random where it fits
	function automatic octets_t tlv_header(input logic [15:0] tg, input int unsigned n);
		octets_t     h;
		int unsigned form;
		logic [31:0] len;
		len = n;
		if (tg[15])
			h = {tg[15:8], tg[7:0]};
		else
			h = {tg[7:0]};
		form = $urandom_range(9);
		if (n < 254 && form < 7)
			h.push_back(len[7:0]);
		else if (n <= 32'hFFFF && form < 9)
			h = {h, LEN_ESC16, len[15:8], len[7:0]};
		else
			h = {h, LEN_ESC32, len[31:24], len[23:16], len[15:8], len[7:0]};
		return h;
	endfunction

	function automatic octets_t rand_prim();
		octets_t     e;
		int unsigned n;
		n = ($urandom_range(19) == 0) ? $urandom_range(300, 250) : $urandom_range(6);
		e = tlv_header(rand_tag(1'b0), n);
		repeat (n) e.push_back(8'($urandom));
		return e;
	endfunction

	// a chain of constructed levels with primitive siblings, then the fault
	function automatic octets_t build_pdu(input fault_t fault, input int unsigned nest);
		octets_t     body;
		octets_t     hdr;
		int unsigned bad_lvl;
		int unsigned n;
		body = {};
		if (fault == FAULT_NOISE) begin
			repeat ($urandom_range(12, 1)) body.push_back(8'($urandom));
			return body;
		end
		repeat ($urandom_range(2, 1)) body = {body, rand_prim()};
		if (fault == FAULT_EMPTY)
			body = {body, tlv_header(rand_tag(1'b1), 0)};
		bad_lvl = $urandom_range((nest > 0) ? nest - 1 : 0);
		for (int k = 0; k < nest; k++) begin
			n = body.size();
			if (fault == FAULT_OVERRUN && k == bad_lvl)
				n--;
			hdr = tlv_header(rand_tag(1'b1), n);
			body = {hdr, body};
			if ($urandom_range(3) == 0)
				body = {rand_prim(), body};
			if ($urandom_range(3) == 0)
				body = {body, rand_prim()};
		end
		if (fault == FAULT_HUGE) begin
			body = {body, tlv_header(rand_tag(1'b0), $urandom | 32'h0001_0000)};
			repeat ($urandom_range(4)) body.push_back(8'($urandom));
		end
		if (fault == FAULT_CUT && body.size() > 1)
			repeat ($urandom_range(body.size() - 1, 1)) void'(body.pop_back());
		return body;
	endfunction

	// ------------------------------------------------------------------
	// directed table rows
	// ------------------------------------------------------------------

	function automatic stim_row_t pred_row(input logic [7:0] b, input logic last);
		stim_row_t s;
		s.data = b;
		s.last = last;
		s.fixed = 1'b0;
		s.res = '0;
		return s;
	endfunction

	function automatic stim_row_t fixed_row(input logic [7:0] b, input logic last,
			input logic [1:0] role, input logic hd, input logic [15:0] tg,
			input logic [31:0] vl, input logic cons, input logic [3:0] dep,
			input logic [3:0] closed, input logic [2:0] st);
		stim_row_t s;
		s.data = b;
		s.last = last;
		s.fixed = 1'b1;
		s.res = {role, hd, tg, vl, cons, dep, closed, st, last};
		return s;
	endfunction

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------

	// offer one byte from a falling edge and return at the falling edge after
	// its transaction, with valid still high
	task automatic send_byte(input logic [7:0] b, input logic last, input logic fixed,
			input result_t res);
		while (idle_on && $urandom_range(99) < 33) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		pdu_last = last;
		fixed_valid = fixed;
		fixed_res = res;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// receiver: random stalls, or one long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall = idle_on && ($urandom_range(99) < 33);
		end
	end

	// ------------------------------------------------------------------
	// prediction and checking
	// ------------------------------------------------------------------

	task automatic cmp_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
		end
	endtask

	task automatic check_result(input result_t want, input result_t got);
		cmp_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
		cmp_field("header_done", 32'(want.header_done), 32'(got.header_done));
		cmp_field("tag", 32'(want.tag), 32'(got.tag));
		cmp_field("value_length", want.value_length, got.value_length);
		cmp_field("constructed", 32'(want.constructed), 32'(got.constructed));
		cmp_field("depth", 32'(want.depth), 32'(got.depth));
		cmp_field("levels_closed", 32'(want.levels_closed), 32'(got.levels_closed));
		cmp_field("status", 32'(want.status), 32'(got.status));
		cmp_field("pdu_done", 32'(want.pdu_done), 32'(got.pdu_done));
	endtask

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			// input transaction: step the model, queue the prediction
			if (in_taken) begin
				want = parse_byte(data_byte, pdu_last);
				if (want.byte_role != ROLE_IGN)
					parsed_items++;
				if (int'(want.depth) > deepest)
					deepest = int'(want.depth);
				if (pdu_last) begin
					pdus_seen++;
					if (want.status != ST_OK)
						error_pdus++;
				end
				if (fixed_valid)
					want = fixed_res;
				pending_results.push_back(want);
			end
			// result transaction: compare with the oldest prediction
			if (out_taken) begin
				results_seen++;
				got = {byte_role, header_done, tag, value_length, constructed, depth,
					levels_closed, status, pdu_done};
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with no byte outstanding, got 0x%0h", $time, got);
				end else begin
					check_result(pending_results.pop_front(), got);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || in_taken || out_taken)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
			$display("[tlv_stream_parser_top] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin
		stim_row_t   rows [$];
		octets_t     pdu;
		fault_t      fault;
		int unsigned nest;
		int unsigned pick;
		int          pdu_count;
		logic        hold_done;
		pdu_count = 0;
		hold_done = 1'b0;
		clear_parser();

		rows = {
			// zero-length primitive straight after reset
			fixed_row(8'h01, 1'b0, ROLE_TAG, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd0, 4'd0, ST_OK),
			fixed_row(8'h00, 1'b1, ROLE_LEN, 1'b1, 16'h0001, 32'h0, 1'b0, 4'd0, 4'd1, ST_OK),
			// widest tag and 32-bit length, saturating end, pdu ends inside it
			fixed_row(8'hFF, 1'b0, ROLE_TAG, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd0, 4'd0, ST_OK),
			fixed_row(8'hFF, 1'b0, ROLE_TAG, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd0, 4'd0, ST_OK),
			pred_row(8'hFF, 1'b0),
			pred_row(8'hFF, 1'b0),
			pred_row(8'hFF, 1'b0),
			pred_row(8'hFF, 1'b0),
			fixed_row(8'hFF, 1'b1, ROLE_LEN, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd0, 4'd0,
				ST_TRUNC),
			// empty constructed, then ignored bytes
			pred_row(8'h7F, 1'b0),
			fixed_row(8'h00, 1'b0, ROLE_LEN, 1'b1, 16'h007F, 32'h0, 1'b1, 4'd0, 4'd0, ST_EMPTY),
			fixed_row(8'h55, 1'b0, ROLE_IGN, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd0, 4'd0, ST_EMPTY),
			fixed_row(8'hAA, 1'b1, ROLE_IGN, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd0, 4'd0, ST_EMPTY),
			// child header cut off by the end of its parent
			pred_row(8'h60, 1'b0),
			pred_row(8'h03, 1'b0),
			pred_row(8'h01, 1'b0),
			pred_row(8'hFE, 1'b0),
			fixed_row(8'h00, 1'b0, ROLE_LEN, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd1, 4'd0,
				ST_OVERRUN),
			fixed_row(8'h80, 1'b1, ROLE_IGN, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd0, 4'd0,
				ST_OVERRUN),
			// child and parent close on the same byte
			pred_row(8'h60, 1'b0),
			pred_row(8'h02, 1'b0),
			pred_row(8'h05, 1'b0),
			fixed_row(8'h00, 1'b1, ROLE_LEN, 1'b1, 16'h0005, 32'h0, 1'b0, 4'd1, 4'd2, ST_OK),
			// one value byte closing its primitive
			pred_row(8'h02, 1'b0),
			pred_row(8'h01, 1'b0),
			fixed_row(8'hC3, 1'b1, ROLE_VALUE, 1'b0, 16'h0000, 32'h0, 1'b0, 4'd0, 4'd1, ST_OK)
		};

		// reset once
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		idle_on = 1'b1;
		foreach (rows[i])
			send_byte(rows[i].data, rows[i].last, rows[i].fixed, rows[i].res);

		// random pdus, mostly well formed
		while (parsed_items < PARSED_ITEMS) begin
			pdu_count++;
			// long hold-off at the receiver inside a stretch with no idling
			if (!hold_done && parsed_items >= PARSED_ITEMS / 4) begin
				idle_on = 1'b0;
				hold_req = 1'b1;
				hold_done = 1'b1;
			end else if (pdu_count % 5 == 0) begin
				// sender pause until the block has emptied
				wait_drained();
			end
			if (hold_done && !idle_on && parsed_items >= PARSED_ITEMS / 2)
				idle_on = 1'b1;

			pick = $urandom_range(99);
			if (pick < 62)
				fault = FAULT_NONE;
			else if (pick < 72)
				fault = FAULT_CUT;
			else if (pick < 78)
				fault = FAULT_OVERRUN;
			else if (pick < 84)
				fault = FAULT_EMPTY;
			else if (pick < 92)
				fault = FAULT_NOISE;
			else
				fault = FAULT_HUGE;

			// one chain in twenty goes a level past the stack
			pick = $urandom_range(19);
			if (pick < 10)
				nest = $urandom_range(2);
			else if (pick < 16)
				nest = $urandom_range(5, 3);
			else if (pick < 19)
				nest = $urandom_range(NEST_LIMIT, 6);
			else
				nest = NEST_LIMIT + 1;

			pdu = build_pdu(fault, nest);
			foreach (pdu[i])
				send_byte(pdu[i], i == pdu.size() - 1, 1'b0, '0);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d pdus (%0d ending in error), %0d results checked",
			pdus_seen, error_pdus, results_seen);
		$display("deepest nesting seen %0d, %0d mismatches", deepest, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[tlv_stream_parser_top] OK");
		else
			$display("[tlv_stream_parser_top] ERROR");
		$finish;
	end

endmodule
